### hw/rtl/lcb_pkg.sv
// lcb_pkg: shared types, constants and helpers for the line column balancer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

  localparam int PosBits     = 24;
  localparam int MaxColumns  = 64;
  localparam int ColBits     = 6;
  localparam int CountBits   = 7;
  localparam int FlagBits    = 1;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 24;

  typedef logic [PosBits-1:0]   pos_t;
  typedef logic [ColBits-1:0]   col_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgColumnTotal  = 3'd0,
    CfgColumnPitch  = 3'd1,
    CfgTargetHeight = 3'd2,
    CfgFillAuto     = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    pos_t             line_top;
    pos_t             box_height;
    pos_t             line_left;
    logic [FlagBits-1:0] last_line;
  } in_word_t;

  typedef struct packed {
    pos_t             placed_left;
    pos_t             placed_top;
    col_t             column_number;
    logic [FlagBits-1:0] is_final;
    count_t           columns_used;
    pos_t             tallest_column;
  } out_word_t;

  // settings as seen by the datapath, column count already clamped
  typedef struct packed {
    count_t col_limit;
    pos_t   column_pitch;
    pos_t   col_target;
    logic   fill_auto;
  } cfg_t;

  function automatic pos_t sat_add(input pos_t a, input pos_t b);
    logic [PosBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PosBits] ? {PosBits{1'b1}} : s[PosBits-1:0];
  endfunction

  function automatic pos_t clamp_sub(input pos_t a, input pos_t b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcb_cfg_regs.sv
// lcb_cfg_regs: settings registers written through the configuration channel
// depends on lcb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcb_cfg_regs
  import lcb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_en_i,
  input  wire logic [CfgIdxBits-1:0]  wr_index_i,
  input  wire logic [CfgDataBits-1:0] wr_data_i,
  output cfg_t                        cfg_o
);

  count_t column_total_q, column_total_d;
  pos_t   column_pitch_q, column_pitch_d;
  pos_t   col_target_q, col_target_d;
  logic   fill_auto_q, fill_auto_d;

  always_comb begin
    column_total_d  = column_total_q;
    column_pitch_d  = column_pitch_q;
    col_target_d    = col_target_q;
    fill_auto_d     = fill_auto_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgColumnTotal:  column_total_d  = wr_data_i[CountBits-1:0];
        CfgColumnPitch:  column_pitch_d  = wr_data_i[PosBits-1:0];
        CfgTargetHeight: col_target_d    = wr_data_i[PosBits-1:0];
        CfgFillAuto:     fill_auto_d     = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_total_q  <= CountBits'(1);
      column_pitch_q  <= '0;
      col_target_q    <= '0;
      fill_auto_q     <= 1'b0;
    end else begin
      column_total_q  <= column_total_d;
      column_pitch_q  <= column_pitch_d;
      col_target_q    <= col_target_d;
      fill_auto_q     <= fill_auto_d;
    end
  end

  // zero counts as one column, anything above the maximum as the maximum
  always_comb begin
    if (column_total_q == '0) begin
      cfg_o.col_limit = CountBits'(1);
    end else if (column_total_q > CountBits'(MaxColumns)) begin
      cfg_o.col_limit = CountBits'(MaxColumns);
    end else begin
      cfg_o.col_limit = column_total_q;
    end
    cfg_o.column_pitch  = column_pitch_q;
    cfg_o.col_target    = col_target_q;
    cfg_o.fill_auto     = fill_auto_q;
  end

endmodule

`default_nettype wire

### hw/rtl/lcb_place_core.sv
// lcb_place_core: group state registers and single-pass column placement logic
// depends on lcb_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcb_place_core
  import lcb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire in_word_t word_i,
  input  wire cfg_t     cfg_i,
  output out_word_t result_o
);

  pos_t ref_top_q, ref_top_d;
  pos_t col_start_q, col_start_d;
  logic begun_q, begun_d;
  col_t cur_col_q, cur_col_d;
  pos_t col_offset_q, col_offset_d;
  pos_t tallest_q, tallest_d;

  pos_t   ref_eff, rel, off0, with0, over, under, off, col_fill;
  pos_t   col_start_n, col_offset_n, tall_n, tall_fin;
  col_t   cur_n;
  logic   can_break, do_break, last;

  always_comb begin
    last      = word_i.last_line[0];
    ref_eff   = begun_q ? ref_top_q : word_i.line_top;
    rel       = clamp_sub(word_i.line_top, ref_eff);
    can_break = begun_q && ((CountBits'(cur_col_q) + CountBits'(1)) < cfg_i.col_limit);
    off0      = clamp_sub(rel, col_start_q);
    with0     = sat_add(off0, word_i.box_height);
    over      = with0 - cfg_i.col_target;
    under     = clamp_sub(cfg_i.col_target, off0);
    do_break  = can_break && (with0 > cfg_i.col_target) &&
                (cfg_i.fill_auto || (under <= over));

    col_start_n  = do_break ? rel : col_start_q;
    cur_n        = do_break ? (cur_col_q + col_t'(1)) : cur_col_q;
    col_offset_n = do_break ? sat_add(col_offset_q, cfg_i.column_pitch) : col_offset_q;
    tall_n       = (do_break && (off0 > tallest_q)) ? off0 : tallest_q;

    // a fresh column starts at this line
    off      = do_break ? '0 : off0;
    col_fill = do_break ? word_i.box_height : with0;
    tall_fin = (col_fill > tall_n) ? col_fill : tall_n;

    result_o.placed_left    = sat_add(word_i.line_left, col_offset_n);
    result_o.placed_top     = sat_add(ref_eff, off);
    result_o.column_number  = cur_n;
    result_o.is_final       = word_i.last_line;
    result_o.columns_used   = last ? (CountBits'(cur_n) + CountBits'(1)) : '0;
    result_o.tallest_column = last ? tall_fin : '0;
  end

  always_comb begin
    ref_top_d    = ref_top_q;
    col_start_d  = col_start_q;
    begun_d      = begun_q;
    cur_col_d    = cur_col_q;
    col_offset_d = col_offset_q;
    tallest_d    = tallest_q;
    if (step_i) begin
      if (last) begin
        ref_top_d    = '0;
        col_start_d  = '0;
        begun_d      = 1'b0;
        cur_col_d    = '0;
        col_offset_d = '0;
        tallest_d    = '0;
      end else begin
        ref_top_d    = ref_eff;
        col_start_d  = col_start_n;
        begun_d      = 1'b1;
        cur_col_d    = cur_n;
        col_offset_d = col_offset_n;
        tallest_d    = tall_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_top_q    <= '0;
      col_start_q  <= '0;
      begun_q      <= 1'b0;
      cur_col_q    <= '0;
      col_offset_q <= '0;
      tallest_q    <= '0;
    end else begin
      ref_top_q    <= ref_top_d;
      col_start_q  <= col_start_d;
      begun_q      <= begun_d;
      cur_col_q    <= cur_col_d;
      col_offset_q <= col_offset_d;
      tallest_q    <= tallest_d;
    end
  end

  a_group_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last) |=> (!begun_q && cur_col_q == '0 && col_offset_q == '0))
    else $error("group state not cleared after last line");

  a_column_needs_begun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q != '0) |-> begun_q)
    else $error("column advanced without a begun group");

  a_first_column_unshifted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q == '0) |-> (col_offset_q == '0))
    else $error("first column carries an x shift");

endmodule

`default_nettype wire

### hw/rtl/line_column_balancer.sv
// line_column_balancer: top level, input register, placement core, result register
// depends on lcb_pkg, lcb_cfg_regs, lcb_place_core
//
//   channel | direction | handshake             | word
//   in      | sink      | in_valid_i/in_ready_o | in_word_t
//   out     | source    | out_valid_o/out_ready_i | out_word_t
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle unless stalled; words pass the input register, then the result register
// the column state update and placement share one pass between the input and result registers
// a stalled result holds the input register; with both full, in_ready_o follows out_ready_i
// reset clears the settings to their defaults and the group state to zero
`timescale 1ns / 1ps
`default_nettype none

module line_column_balancer
  import lcb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire in_word_t               in_word_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output out_word_t                   out_word_o,
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t out_q, result;
  logic      out_valid_q;
  logic      advance, step;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;

  lcb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lcb_place_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_held_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
    else $error("input register lost a stalled word");

  a_nonfinal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_final[0]) |->
      (out_q.columns_used == '0 && out_q.tallest_column == '0))
    else $error("group summary on a line that is not final");

  a_final_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_final[0]) |->
      (out_q.columns_used == (CountBits'(out_q.column_number) + CountBits'(1))))
    else $error("used column count disagrees with last column");

endmodule

`default_nettype wire
